// ===== rtl/ffba_pkg.sv =====
// Shared constants, command codes and controller/datapath interface types.
package ffba_pkg;

  localparam int unsigned ARENA_UNITS_DEF  = 1024;
  localparam int unsigned HEADER_UNITS_DEF = 1;

  localparam int unsigned REQ_W = 11;
  localparam int unsigned OFF_W = 10;
  localparam int unsigned CFG_W = 11;

  localparam int unsigned IN_TDATA_W  = ((REQ_W + OFF_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((OFF_W + 7) / 8) * 8;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_INIT,
    OP_A_STEP,
    OP_A_MARK,
    OP_A_SPLIT,
    OP_A_LINK,
    OP_F_CLEAR,
    OP_F_PREV,
    OP_F_NEXT,
    OP_F_MERGE,
    OP_F_WNEXT,
    OP_F_WPREV
  } op_t;

  typedef struct packed {
    op_t  op;
    logic accept;
    logic res_set;
    logic res_ok;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic a_broken;
    logic a_fit;
    logic a_last;
    logic a_split;
    logic a_link;
    logic f_bad;
    logic f_link;
  } dp_status_t;

endpackage

// ===== rtl/ffba_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module ffba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ffba_ctrl.sv =====
// Controller state machine sequencing allocate and free requests.
module ffba_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic                in_tvalid,
  input  logic                in_is_free,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  output ffba_pkg::dp_cmd_t    cmd,
  input  ffba_pkg::dp_status_t sts
);
  import ffba_pkg::*;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_A_STEP,
    S_A_MARK,
    S_A_SPLIT,
    S_A_LINK,
    S_F_CLEAR,
    S_F_PREV,
    S_F_NEXT,
    S_F_MERGE,
    S_F_WNEXT,
    S_F_WPREV,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.op       = OP_NONE;
    in_tready    = 1'b0;
    unique case (state_r)
      S_INIT: begin
        cmd.op    = OP_INIT;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready = !cfg_wr_en;
        if (in_tvalid && !cfg_wr_en) begin
          cmd.accept = 1'b1;
          state_nxt  = (in_is_free == CMD_FREE) ? S_F_CLEAR : S_A_STEP;
        end
      end
      S_A_STEP: begin
        cmd.op = OP_A_STEP;
        if (sts.a_broken || (!sts.a_fit && sts.a_last)) begin
          cmd.res_set = 1'b1;
          state_nxt   = S_RESP;
        end else if (sts.a_fit) begin
          state_nxt = S_A_MARK;
        end
      end
      S_A_MARK: begin
        cmd.op      = OP_A_MARK;
        cmd.res_set = 1'b1;
        cmd.res_ok  = 1'b1;
        state_nxt   = sts.a_split ? S_A_SPLIT : S_RESP;
      end
      S_A_SPLIT: begin
        cmd.op    = OP_A_SPLIT;
        state_nxt = sts.a_link ? S_A_LINK : S_RESP;
      end
      S_A_LINK: begin
        cmd.op    = OP_A_LINK;
        state_nxt = S_RESP;
      end
      S_F_CLEAR: begin
        cmd.op = OP_F_CLEAR;
        if (sts.f_bad) begin
          cmd.res_set = 1'b1;
          state_nxt   = S_RESP;
        end else begin
          state_nxt = S_F_PREV;
        end
      end
      S_F_PREV: begin
        cmd.op    = OP_F_PREV;
        state_nxt = S_F_NEXT;
      end
      S_F_NEXT: begin
        cmd.op    = OP_F_NEXT;
        state_nxt = S_F_MERGE;
      end
      S_F_MERGE: begin
        cmd.op    = OP_F_MERGE;
        state_nxt = S_F_WNEXT;
      end
      S_F_WNEXT: begin
        cmd.op      = OP_F_WNEXT;
        cmd.res_set = 1'b1;
        cmd.res_ok  = 1'b1;
        state_nxt   = sts.f_link ? S_F_WPREV : S_RESP;
      end
      S_F_WPREV: begin
        cmd.op    = OP_F_WPREV;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
    if (cfg_wr_en) begin
      state_nxt = S_INIT;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// ===== rtl/ffba_dp.sv =====
// Datapath: header memories, chain walk registers, merge logic and result registers.
module ffba_dp #(
  parameter int unsigned ARENA_UNITS  = ffba_pkg::ARENA_UNITS_DEF,
  parameter int unsigned HEADER_UNITS = ffba_pkg::HEADER_UNITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [ffba_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                       in_is_free,
  input  logic [ffba_pkg::REQ_W-1:0] in_request_units,
  input  logic [ffba_pkg::OFF_W-1:0] in_release_offset,
  output logic                       out_success,
  output logic [ffba_pkg::OFF_W-1:0] out_granted_offset,
  input  ffba_pkg::dp_cmd_t           cmd,
  output ffba_pkg::dp_status_t        sts
);
  import ffba_pkg::*;

  localparam int unsigned AW = $clog2(ARENA_UNITS);
  localparam int unsigned LW = $clog2(ARENA_UNITS + 1);
  localparam int unsigned MW = (LW > CFG_W) ? LW : CFG_W;
  localparam int unsigned CW = ((LW > REQ_W) ? LW : REQ_W) + 1;

  // Configuration and request registers
  logic [LW-1:0]    arena_r;
  logic [MW-1:0]    cfg_ext;
  logic [MW-1:0]    arena_clamp;
  logic             free_r;
  logic [REQ_W-1:0] req_r;
  logic [OFF_W-1:0] off_r;

  // Walk and merge registers
  logic [AW-1:0] cur_r;
  logic [CW-1:0] nx_r, data_r, nb_r, lft_r;
  logic [LW-1:0] b_r, p_r, fn_r, begin_r, new_end_r;
  logic          pfree_r;

  logic             res_ok_r;
  logic [OFF_W-1:0] res_off_r;

  // Memory ports
  logic          we_used, we_prev, we_next;
  logic [AW-1:0] waddr, raddr;
  logic          wd_used;
  logic [LW-1:0] wd_prev, wd_next;
  logic          rd_used;
  logic [LW-1:0] rd_prev, rd_next;

  // Arithmetic in a common width
  logic [CW-1:0] arena_c, h_c, cur_c, nx_c, data_c, req_c, size_c, off_c, b_c;
  logic          fit, f_bad, nfree;

  assign cfg_ext     = MW'(cfg_wr_data);
  assign arena_clamp = (cfg_ext > MW'(ARENA_UNITS)) ? MW'(ARENA_UNITS) :
                       (cfg_ext < MW'(2))           ? MW'(2) : cfg_ext;

  assign arena_c = CW'(arena_r);
  assign h_c     = CW'(HEADER_UNITS);
  assign cur_c   = CW'(cur_r);
  assign nx_c    = CW'(rd_next);
  assign data_c  = cur_c + h_c;
  assign req_c   = CW'(req_r);
  assign size_c  = nx_c - data_c;
  assign fit     = !rd_used && (nx_c >= data_c) && (size_c >= req_c);
  assign off_c   = CW'(off_r);
  assign b_c     = off_c - h_c;
  assign f_bad   = (off_c < h_c) || (b_c >= arena_c);
  assign nfree   = (fn_r < arena_r) && !rd_used;

  always_comb begin
    sts.a_broken = (nx_c <= cur_c) || (nx_c > arena_c);
    sts.a_fit    = fit;
    sts.a_last   = (nx_c == arena_c);
    sts.a_split  = (lft_r > h_c);
    sts.a_link   = (nx_r < arena_c);
    sts.f_bad    = f_bad;
    sts.f_link   = (new_end_r < arena_r);
  end

  always_comb begin
    we_used = 1'b0;
    we_prev = 1'b0;
    we_next = 1'b0;
    waddr   = '0;
    wd_used = 1'b0;
    wd_prev = '0;
    wd_next = '0;
    raddr   = '0;
    case (cmd.op)
      OP_INIT: begin
        we_used = 1'b1;
        we_prev = 1'b1;
        we_next = 1'b1;
        wd_next = arena_r;
      end
      OP_A_STEP: raddr = nx_c[AW-1:0];
      OP_A_MARK: begin
        waddr   = cur_r;
        we_used = 1'b1;
        wd_used = 1'b1;
        we_next = sts.a_split;
        wd_next = nb_r[LW-1:0];
      end
      OP_A_SPLIT: begin
        waddr   = nb_r[AW-1:0];
        we_used = 1'b1;
        we_prev = 1'b1;
        we_next = 1'b1;
        wd_prev = LW'(cur_r);
        wd_next = nx_r[LW-1:0];
      end
      OP_A_LINK: begin
        waddr   = nx_r[AW-1:0];
        we_prev = 1'b1;
        wd_prev = nb_r[LW-1:0];
      end
      OP_F_CLEAR: begin
        waddr   = b_c[AW-1:0];
        raddr   = b_c[AW-1:0];
        we_used = !f_bad;
      end
      OP_F_PREV: raddr = rd_prev[AW-1:0];
      OP_F_NEXT: raddr = fn_r[AW-1:0];
      OP_F_WNEXT: begin
        waddr   = begin_r[AW-1:0];
        we_next = 1'b1;
        wd_next = new_end_r;
      end
      OP_F_WPREV: begin
        waddr   = new_end_r[AW-1:0];
        we_prev = 1'b1;
        wd_prev = begin_r;
      end
      default: raddr = '0;
    endcase
  end

  ffba_ram #(.WIDTH(1), .DEPTH(ARENA_UNITS)) u_used (
    .clk(clk), .we(we_used), .waddr(waddr), .wdata(wd_used), .raddr(raddr), .rdata(rd_used)
  );

  ffba_ram #(.WIDTH(LW), .DEPTH(ARENA_UNITS)) u_prev (
    .clk(clk), .we(we_prev), .waddr(waddr), .wdata(wd_prev), .raddr(raddr), .rdata(rd_prev)
  );

  ffba_ram #(.WIDTH(LW), .DEPTH(ARENA_UNITS)) u_next (
    .clk(clk), .we(we_next), .waddr(waddr), .wdata(wd_next), .raddr(raddr), .rdata(rd_next)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arena_r <= LW'(ARENA_UNITS);
    end else if (cfg_wr_en) begin
      arena_r <= arena_clamp[LW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      free_r <= in_is_free;
      req_r  <= in_request_units;
      off_r  <= in_release_offset;
      cur_r  <= '0;
    end
    if (cmd.op == OP_A_STEP) begin
      // The walk only moves on when this block is not taken; a fitting block
      // stays addressed for the header writes that follow.
      if (!fit) begin
        cur_r <= nx_c[AW-1:0];
      end
      nx_r   <= nx_c;
      data_r <= data_c;
      nb_r   <= data_c + req_c;
      lft_r  <= size_c - req_c;
    end
    if (cmd.op == OP_F_CLEAR) begin
      b_r <= b_c[LW-1:0];
    end
    if (cmd.op == OP_F_PREV) begin
      p_r  <= rd_prev;
      fn_r <= rd_next;
    end
    if (cmd.op == OP_F_NEXT) begin
      pfree_r <= (p_r < arena_r) && !rd_used;
    end
    if (cmd.op == OP_F_MERGE) begin
      begin_r   <= pfree_r ? p_r : b_r;
      new_end_r <= nfree ? rd_next : fn_r;
    end
    if (cmd.res_set) begin
      res_ok_r  <= cmd.res_ok;
      res_off_r <= (cmd.res_ok && (free_r == CMD_ALLOC)) ? data_r[OFF_W-1:0] : '0;
    end
    if (cmd.load_out) begin
      out_success        <= res_ok_r;
      out_granted_offset <= res_off_r;
    end
  end

endmodule

// ===== rtl/first_fit_block_allocator.sv =====
// Top level of the first-fit block allocator: controller, datapath and stream ports.
// An allocate reads one header per block walked (on the shared header read address),
// then marks the fitting block; a split adds a header write for the new block and,
// if it has a successor, one for the successor's back link (up to two). A free clears
// the flag, reads the previous and next headers, merges, rewrites the forward link and,
// if the merged block has a successor, its back link; a refused free ends after the clear.
// Throughput: one request at a time; a new request is taken once the previous result
// has been registered, even while that result still waits on the output.
// Reset (synchronous, active low) and every arena_size write pass through an init state
// that writes the first header; no request is taken in that state.
module first_fit_block_allocator #(
  parameter int unsigned ARENA_UNITS  = ffba_pkg::ARENA_UNITS_DEF,
  parameter int unsigned HEADER_UNITS = ffba_pkg::HEADER_UNITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input request channel
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // in_tdata from bit 0: request_units (11), release_offset (10), zero padding
  input  logic [ffba_pkg::IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: cmd (0 allocate, 1 free)
  input  logic                             in_tuser,
  // Result channel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_tdata from bit 0: granted_offset (10), zero padding
  output logic [ffba_pkg::OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: success
  output logic                             out_tuser,
  // Configuration: arena_size
  input  logic                             cfg_wr_en,
  input  logic [ffba_pkg::CFG_W-1:0]       cfg_wr_data
);
  import ffba_pkg::*;

  dp_cmd_t          cmd;
  dp_status_t       sts;
  logic [OFF_W-1:0] granted_offset;

  // The controller owns sequencing and the output valid flag; it never sees data.
  ffba_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .in_tvalid  (in_tvalid),
    .in_is_free (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  // The datapath holds the block headers as three memories (allocated flag, previous
  // start, next start) sharing one write address and one read address, so that each
  // link can be updated on its own without a read-modify-write.
  ffba_dp #(
    .ARENA_UNITS  (ARENA_UNITS),
    .HEADER_UNITS (HEADER_UNITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_is_free         (in_tuser),
    .in_request_units   (in_tdata[REQ_W-1:0]),
    .in_release_offset  (in_tdata[REQ_W+OFF_W-1:REQ_W]),
    .out_success        (out_tuser),
    .out_granted_offset (granted_offset),
    .cmd                (cmd),
    .sts                (sts)
  );

  // Padding bits of the result are held at zero.
  assign out_tdata = OUT_TDATA_W'(granted_offset);

endmodule

// ===== rtl/ffba_checker.sv =====
// Port-level checker for the first-fit block allocator, bound to the top level.
module ffba_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [ffba_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tuser,
  input logic                             cfg_wr_en
);

  // A result waiting on the output keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // A failed request never carries an offset.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("failed request shows a non-zero offset");

  // One request at a time: the block is busy straight after taking one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while previous one in progress");

  // An arena size write reinitialises the headers before the next request.
  a_init_after_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> !in_tready)
    else $error("request taken during arena reinitialisation");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (.*);
